FILE: hw/rtl/gfw_pkg.sv
// ----------------------------------------------------------------------------
// gfw_pkg: shared definitions for the GF(2^w) arithmetic unit
// Field sizes, register reset values, request and status codes, and the
// configuration bundle passed from the register block to the core.
// ----------------------------------------------------------------------------
`default_nettype none

package gfw_pkg;

  localparam int unsigned GF_MAX_WIDTH = 32;
  localparam int unsigned OPERAND_W    = 32;
  localparam int unsigned CFG_WIDTH_W  = 6;
  localparam int unsigned CFG_POLY_W   = 33;
  localparam int unsigned APB_DATA_W   = 64;
  localparam int unsigned APB_ADDR_W   = 4;

  localparam logic [CFG_WIDTH_W-1:0] GF_WIDTH_RST   = 6'd8;
  localparam logic [CFG_POLY_W-1:0]  FIELD_POLY_RST = 33'o435;

  typedef enum logic [1:0] {
    REQ_MUL = 2'd0,
    REQ_DIV = 2'd1,
    REQ_INV = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [CFG_WIDTH_W-1:0] gf_width;
    logic [CFG_POLY_W-1:0]  field_poly;
  } gfw_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gf2w_multiply_divide_inverse.sv
// ----------------------------------------------------------------------------
// gf2w_multiply_divide_inverse: GF(2^w) multiply, divide and inverse unit
// Multiplies, divides or inverts field elements for a programmable width and
// reducing polynomial, one request at a time.
// ----------------------------------------------------------------------------
// A rejected request strobes its result in the cycle after acceptance, a
//   multiply runs one shift-and-add pass per multiplier bit, and a divide
//   runs an inverse then a multiply.
// Throughput: one request in flight; busy falls as the result strobe shows and
//   a new request is taken in that same cycle. The receiver cannot stall.
// Reset: the unit goes idle, width returns to 8 and the polynomial to 0435.
`default_nettype none

module gf2w_multiply_divide_inverse
  import gfw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = GF_MAX_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [OPERAND_W-1:0]  operand_a_i,
  input  wire logic [OPERAND_W-1:0]  operand_b_i,
  output logic                       result_valid_o,
  output logic      [OPERAND_W-1:0]  result_o,
  output logic      [1:0]            status_o
);

  gfw_cfg_t cfg;

  gfw_apb_regs u_apb_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gfw_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .start          (start),
    .req_type_i     (req_type_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/gfw_apb_regs.sv
// ----------------------------------------------------------------------------
// gfw_apb_regs: configuration registers
// Holds the field width and the reducing polynomial behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module gfw_apb_regs
  import gfw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output gfw_cfg_t                   cfg_o
);

  // Registers sit on 8-byte boundaries, so bit 3 selects one of them.
  typedef enum logic {
    REG_GF_WIDTH   = 1'b0,
    REG_FIELD_POLY = 1'b1
  } reg_idx_e;

  logic [CFG_WIDTH_W-1:0] gf_width_q;
  logic [CFG_POLY_W-1:0]  field_poly_q;
  logic                   wr_en;
  reg_idx_e               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gf_width_q   <= GF_WIDTH_RST;
      field_poly_q <= FIELD_POLY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GF_WIDTH:   gf_width_q   <= pwdata[CFG_WIDTH_W-1:0];
        REG_FIELD_POLY: field_poly_q <= pwdata[CFG_POLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GF_WIDTH:   prdata = APB_DATA_W'(gf_width_q);
      REG_FIELD_POLY: prdata = APB_DATA_W'(field_poly_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.gf_width   = gf_width_q;
  assign cfg_o.field_poly = field_poly_q;

endmodule

`default_nettype wire

FILE: hw/rtl/gfw_euclid_step.sv
// ----------------------------------------------------------------------------
// gfw_euclid_step: one step of the binary extended Euclidean algorithm
// Cancels the leading term of the higher-degree remainder with a shifted copy
// of the other one, and applies the same shift-and-add to the cofactors.
// ----------------------------------------------------------------------------
`default_nettype none

module gfw_euclid_step #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  wire logic [MAX_WIDTH:0]             u_i,
  input  wire logic [MAX_WIDTH:0]             v_i,
  input  wire logic [MAX_WIDTH:0]             g1_i,
  input  wire logic [MAX_WIDTH:0]             g2_i,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0] du_i,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0] dv_i,
  output logic      [MAX_WIDTH:0]             u_o,
  output logic      [MAX_WIDTH:0]             v_o,
  output logic      [MAX_WIDTH:0]             g1_o,
  output logic      [MAX_WIDTH:0]             g2_o,
  output logic      [$clog2(MAX_WIDTH+1)-1:0] du_o,
  output logic      [$clog2(MAX_WIDTH+1)-1:0] dv_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic          swap;
  logic [WW-1:0] shamt;
  logic [WW-1:0] d_big;

  // When u has the lower degree the two pairs trade places in the same step,
  // so every step lowers the sum of the two degree counters by one.
  assign swap  = du_i < dv_i;
  assign shamt = swap ? (dv_i - du_i) : (du_i - dv_i);
  assign d_big = swap ? dv_i : du_i;

  assign u_o  = (swap ? v_i : u_i) ^ ((swap ? u_i : v_i) << shamt);
  assign g1_o = (swap ? g2_i : g1_i) ^ ((swap ? g1_i : g2_i) << shamt);
  assign v_o  = swap ? u_i : v_i;
  assign g2_o = swap ? g1_i : g2_i;
  assign du_o = d_big - WW'(1);
  assign dv_o = swap ? du_i : dv_i;

endmodule

`default_nettype wire

FILE: hw/rtl/gfw_core.sv
// ----------------------------------------------------------------------------
// gfw_core: request sequencer and datapath registers
// Checks operands, runs the inversion loop through the shared Euclid step and
// the shift-and-add multiply loop, and registers the result with its status.
// ----------------------------------------------------------------------------
`default_nettype none

module gfw_core
  import gfw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = GF_MAX_WIDTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire gfw_cfg_t             cfg_i,
  input  wire logic                 start,
  input  wire logic [1:0]           req_type_i,
  input  wire logic [OPERAND_W-1:0] operand_a_i,
  input  wire logic [OPERAND_W-1:0] operand_b_i,
  output logic                      busy,
  output logic                      result_valid_o,
  output logic      [OPERAND_W-1:0] result_o,
  output logic      [1:0]           status_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = MAX_WIDTH + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INV,
    S_MUL
  } state_e;

  state_e               state_q;
  logic                 is_div_q;
  logic [WW-1:0]        w_q;
  logic [PW-1:0]        m_q;
  logic [MAX_WIDTH-1:0] a_q;
  logic [MAX_WIDTH-1:0] b_q;
  logic [MAX_WIDTH-1:0] acc_q;
  logic [CW-1:0]        cnt_q;
  logic [PW-1:0]        u_q;
  logic [PW-1:0]        v_q;
  logic [PW-1:0]        g1_q;
  logic [PW-1:0]        g2_q;
  logic [WW-1:0]        du_q;
  logic [WW-1:0]        dv_q;
  logic [MAX_WIDTH-1:0] result_q;
  status_e              status_q;
  logic                 valid_q;

  logic [WW-1:0]        w_eff;
  logic [PW-1:0]        top_bit;
  logic [PW-1:0]        modulus;
  logic                 req_known;
  logic                 a_big;
  logic                 b_big;
  logic [PW-1:0]        mul_t;
  logic [MAX_WIDTH-1:0] mul_next;
  logic [PW-1:0]        inv_full;
  logic [PW-1:0]        u_n;
  logic [PW-1:0]        v_n;
  logic [PW-1:0]        g1_n;
  logic [PW-1:0]        g2_n;
  logic [WW-1:0]        du_n;
  logic [WW-1:0]        dv_n;

  // Width zero behaves as one and anything above the datapath width is clamped.
  always_comb begin
    if (cfg_i.gf_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_i.gf_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = cfg_i.gf_width[WW-1:0];
    end
  end

  // The x^w term is implied; register bits from w upwards are ignored.
  assign top_bit   = PW'(1) << w_eff;
  assign modulus   = top_bit | (cfg_i.field_poly[PW-1:0] & (top_bit - PW'(1)));
  assign req_known = req_type_i inside {REQ_MUL, REQ_DIV, REQ_INV};
  assign a_big     = (operand_a_i >> w_eff) != '0;
  assign b_big     = (operand_b_i >> w_eff) != '0;

  always_comb begin
    mul_t = {acc_q, 1'b0};
    if (mul_t[w_q]) begin
      mul_t = mul_t ^ m_q;
    end
    if (a_q[cnt_q]) begin
      mul_t = mul_t ^ PW'(b_q);
    end
  end
  assign mul_next = mul_t[MAX_WIDTH-1:0];

  // The cofactor can reach degree w, so one conditional reduction finishes it.
  assign inv_full = g1_q[w_q] ? (g1_q ^ m_q) : g1_q;

  gfw_euclid_step #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_euclid_step (
    .u_i  (u_q),
    .v_i  (v_q),
    .g1_i (g1_q),
    .g2_i (g2_q),
    .du_i (du_q),
    .dv_i (dv_q),
    .u_o  (u_n),
    .v_o  (v_n),
    .g1_o (g1_n),
    .g2_o (g2_n),
    .du_o (du_n),
    .dv_o (dv_n)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      is_div_q <= 1'b0;
      w_q      <= '0;
      m_q      <= '0;
      a_q      <= '0;
      b_q      <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      u_q      <= '0;
      v_q      <= '0;
      g1_q     <= '0;
      g2_q     <= '0;
      du_q     <= '0;
      dv_q     <= '0;
      result_q <= '0;
      status_q <= ST_OK;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            w_q      <= w_eff;
            m_q      <= modulus;
            is_div_q <= (req_type_i == REQ_DIV);
            a_q      <= operand_a_i[MAX_WIDTH-1:0];
            b_q      <= operand_b_i[MAX_WIDTH-1:0];
            if (!req_known || b_big || (req_type_i != REQ_INV && a_big)) begin
              result_q <= '0;
              status_q <= ST_RANGE;
              valid_q  <= 1'b1;
            end else if (req_type_i == REQ_MUL) begin
              acc_q   <= '0;
              cnt_q   <= CW'(w_eff - WW'(1));
              state_q <= S_MUL;
            end else if (operand_b_i == '0) begin
              result_q <= '0;
              status_q <= ST_DIV0;
              valid_q  <= 1'b1;
            end else begin
              u_q     <= PW'(operand_b_i[MAX_WIDTH-1:0]);
              v_q     <= modulus;
              g1_q    <= PW'(1);
              g2_q    <= '0;
              du_q    <= w_eff - WW'(1);
              dv_q    <= w_eff;
              state_q <= S_INV;
            end
          end
        end
        S_INV: begin
          if (u_q == PW'(1)) begin
            if (is_div_q) begin
              b_q     <= inv_full[MAX_WIDTH-1:0];
              acc_q   <= '0;
              cnt_q   <= CW'(w_q - WW'(1));
              state_q <= S_MUL;
            end else begin
              result_q <= inv_full[MAX_WIDTH-1:0];
              status_q <= ST_OK;
              valid_q  <= 1'b1;
              state_q  <= S_IDLE;
            end
          end else if (u_q == '0) begin
            // A common factor with the modulus: no inverse exists.
            result_q <= '0;
            status_q <= ST_DIV0;
            valid_q  <= 1'b1;
            state_q  <= S_IDLE;
          end else if (!u_q[du_q]) begin
            du_q <= du_q - WW'(1);
          end else begin
            u_q  <= u_n;
            v_q  <= v_n;
            g1_q <= g1_n;
            g2_q <= g2_n;
            du_q <= du_n;
            dv_q <= dv_n;
          end
        end
        S_MUL: begin
          acc_q <= mul_next;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            result_q <= mul_next;
            status_q <= ST_OK;
            valid_q  <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = OPERAND_W'(result_q);
  assign status_o       = status_q;

endmodule

`default_nettype wire

FILE: hw/rtl/gfw_checker.sv
// ----------------------------------------------------------------------------
// gfw_checker: port-level checks for the GF(2^w) arithmetic unit
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gfw_checker
  import gfw_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 result_valid_o,
  input wire logic [OPERAND_W-1:0] result_o,
  input wire logic [1:0]           status_o
);

  // An accepted request either finishes at once or keeps the unit busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("accepted request neither started nor finished");

  // The unit only leaves its busy phase by delivering a result.
  a_busy_ends_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  // A result is never shown while a request is still in progress.
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // Failed requests always report a zero element and a defined status.
  a_error_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_OK) |->
      (result_o == '0 && (status_o == ST_DIV0 || status_o == ST_RANGE)))
    else $error("failed request returned a nonzero element or bad status");

endmodule

bind gf2w_multiply_divide_inverse gfw_checker u_gfw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o),
  .status_o       (status_o)
);

`default_nettype wire
